[sv/assert_macros.svh]
// Assertion helpers used by the assertion checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define LRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lru_pkg.sv]
package lru_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_W    = 4;
    localparam int FIDX_W   = 3;
    localparam int COUNT_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic accept;
        logic read;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic last_read;
        logic out_free;
    } status_t;

endpackage

[sv/lru_ctrl.sv]
module lru_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lru_pkg::status_t status,
    output lru_pkg::cmd_t    cmd
);

    lru_pkg::state_t state_reg;
    lru_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lru_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN:
            begin
                if (status.last_read)
                begin
                    state_next = lru_pkg::ST_DRAIN;
                end
            end
            lru_pkg::ST_DRAIN:
            begin
                state_next = lru_pkg::ST_UPDATE;
            end
            lru_pkg::ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = lru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            lru_pkg::ST_SCAN:
            begin
                cmd.read = 1'b1;
            end
            lru_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            lru_pkg::ST_UPDATE:
            begin
                cmd.update = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[sv/lru_dp.sv]
module lru_dp
#(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
    parameter int TIME_BITS = lru_pkg::TIME_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [PAGE_BITS-1:0]         page,
    input  lru_pkg::cmd_t                cmd,
    output lru_pkg::status_t             status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [lru_pkg::FIDX_W-1:0]   frame_index,
    output logic                         evicted_valid,
    output logic [PAGE_BITS-1:0]         evicted_page,
    output logic [lru_pkg::COUNT_W-1:0]  fault_total
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // frame storage, no reset: entries are used only once valid
    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [TIME_BITS-1:0] time_mem [FRAMES];

    logic [lru_pkg::CFG_W-1:0]   cfg_reg;
    logic [FRAMES-1:0]           valid_reg;
    logic [TIME_BITS-1:0]        ref_idx_reg;
    logic [lru_pkg::COUNT_W-1:0] fault_reg;
    logic [PAGE_BITS-1:0]        page_reg;

    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        cmp_en_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;
    logic [PAGE_BITS-1:0]        page_rd_reg;
    logic [TIME_BITS-1:0]        time_rd_reg;
    logic                        vld_rd_reg;

    logic                        hit_found_reg;
    logic [IDX_W-1:0]            hit_idx_reg;
    logic                        empty_found_reg;
    logic [IDX_W-1:0]            empty_idx_reg;
    logic                        best_found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [TIME_BITS-1:0]        best_time_reg;
    logic [PAGE_BITS-1:0]        best_page_reg;

    logic                        out_valid_reg;
    logic                        hit_reg;
    logic [lru_pkg::FIDX_W-1:0]  frame_index_reg;
    logic                        evicted_valid_reg;
    logic [PAGE_BITS-1:0]        evicted_page_reg;

    logic [IDX_W-1:0]            last_idx;
    logic [IDX_W-1:0]            slot;
    logic                        evict;
    logic                        match;
    logic [lru_pkg::COUNT_W-1:0] fault_next;

    // active range: zero acts as one, above FRAMES acts as FRAMES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            last_idx = '0;
        end
        else if ({28'd0, cfg_reg} > 32'(FRAMES))
        begin
            last_idx = IDX_W'(FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'({28'd0, cfg_reg} - 32'd1);
        end
    end

    assign status.last_read = (rd_idx_reg == last_idx);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign match = vld_rd_reg && (page_rd_reg == page_reg);

    always_comb
    begin
        evict = 1'b0;
        if (hit_found_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_idx_reg;
        end
        else
        begin
            slot  = best_idx_reg;
            evict = 1'b1;
        end
    end

    assign fault_next = (!hit_found_reg && (fault_reg != '1)) ? fault_reg + 1'b1 : fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= lru_pkg::CFG_RESET;
            valid_reg       <= '0;
            ref_idx_reg     <= '0;
            fault_reg       <= '0;
            rd_idx_reg      <= '0;
            cmp_en_reg      <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            cmp_en_reg <= cmd.read;
            if (cmd.accept)
            begin
                rd_idx_reg      <= '0;
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
                best_found_reg  <= 1'b0;
            end
            if (cmd.read)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmp_en_reg)
            begin
                if (match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!vld_rd_reg && !empty_found_reg)
                begin
                    empty_found_reg <= 1'b1;
                end
                if (vld_rd_reg && (!best_found_reg || (time_rd_reg < best_time_reg)))
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.update)
            begin
                if (!hit_found_reg)
                begin
                    valid_reg[slot] <= 1'b1;
                end
                fault_reg <= fault_next;
                if (ref_idx_reg != '1)
                begin
                    ref_idx_reg <= ref_idx_reg + 1'b1;
                end
            end
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg <= page;
        end
        if (cmd.read)
        begin
            vld_rd_reg  <= valid_reg[rd_idx_reg];
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmp_en_reg)
        begin
            if (match && !hit_found_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!vld_rd_reg && !empty_found_reg)
            begin
                empty_idx_reg <= cmp_idx_reg;
            end
            if (vld_rd_reg && (!best_found_reg || (time_rd_reg < best_time_reg)))
            begin
                best_idx_reg  <= cmp_idx_reg;
                best_time_reg <= time_rd_reg;
                best_page_reg <= page_rd_reg;
            end
        end
        if (cmd.update)
        begin
            hit_reg           <= hit_found_reg;
            frame_index_reg   <= lru_pkg::FIDX_W'(slot);
            evicted_valid_reg <= evict;
            evicted_page_reg  <= evict ? best_page_reg : '0;
        end
    end

    // frame memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            page_rd_reg <= page_mem[rd_idx_reg];
        end
        if (cmd.update && !hit_found_reg)
        begin
            page_mem[slot] <= page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            time_rd_reg <= time_mem[rd_idx_reg];
        end
        if (cmd.update)
        begin
            time_mem[slot] <= ref_idx_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_reg;

endmodule

[sv/lru_page_replacement.sv]
// The result word is registered after the scan of the active frames, a drain state and the update state.
// One word at a time: input stalls through the one-frame-per-cycle scan of frame memory until the update.
// The next input word is taken while the previous result still waits in the output register.
// Reset (rst_n, async, active low) empties all frames, zeroes the reference index and
// fault count, and sets frames_in_use to 8; frame memories themselves are not cleared.
module lru_page_replacement
#(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
    parameter int TIME_BITS = lru_pkg::TIME_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: frames_in_use
    input  logic                         cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]    cfg_wdata,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [PAGE_BITS-1:0]         page,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic [lru_pkg::FIDX_W-1:0]   frame_index,
    output logic                         evicted_valid,
    output logic [PAGE_BITS-1:0]         evicted_page,
    output logic [lru_pkg::COUNT_W-1:0]  fault_total
);

    lru_pkg::cmd_t    cmd;
    lru_pkg::status_t status;

    // Controller: accept a word, walk the active frames, pass through a drain state for the
    // last compare, then commit the update once the output register is free.
    lru_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: frame memories, valid bits, the scan trackers (first hit,
    // first empty frame, oldest valid frame), counters and the output register.
    lru_dp
    #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .TIME_BITS (TIME_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .page          (page),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

endmodule

[sv/lru_checker.sv]
`include "assert_macros.svh"

module lru_assertions
#(
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         hit,
    input logic [lru_pkg::FIDX_W-1:0]   frame_index,
    input logic                         evicted_valid,
    input logic [PAGE_BITS-1:0]         evicted_page,
    input logic [lru_pkg::COUNT_W-1:0]  fault_total
);

    localparam int WORD_W = 3 + lru_pkg::FIDX_W + PAGE_BITS + lru_pkg::COUNT_W;

    logic [WORD_W-1:0] out_word;
    logic              out_held;
    logic              out_hit;
    logic              out_no_evict;
    logic              in_take;

    assign out_word     = {out_valid, hit, frame_index, evicted_valid, evicted_page, fault_total};
    assign out_held     = out_valid && out_stall;
    assign out_hit      = out_valid && hit;
    assign out_no_evict = out_valid && !evicted_valid;
    assign in_take      = in_valid && !in_stall;

    // a stalled result word holds
    `LRU_ASSERT_NXT(a_out_hold, clk, rst_n, out_held, $stable(out_word), "stalled word changed")

    // a hit never evicts
    `LRU_ASSERT_IMP(a_hit_no_evict, clk, rst_n, out_hit, !evicted_valid, "hit evicted a page")

    // no eviction means a zero evicted page
    `LRU_ASSERT_IMP(a_evict_zero, clk, rst_n, out_no_evict, evicted_page == '0, "stray evicted page")

    // after taking a word the block is busy scanning
    `LRU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_take, in_stall, "input taken twice")

endmodule

bind lru_page_replacement lru_assertions #(.PAGE_BITS(PAGE_BITS)) u_assertions (.*);

[bench/lru_checker.sv]
`timescale 1ns / 1ps

module lru_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [15:0]                   page,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          hit,
    input  logic [lru_pkg::FIDX_W-1:0]    frame_index,
    input  logic                          evicted_valid,
    input  logic [15:0]                   evicted_page,
    input  logic [lru_pkg::COUNT_W-1:0]   fault_total,
    output int                            pending,
    output int                            mismatches
);

    localparam int NUM_FRAMES = lru_pkg::FRAMES_DEF;
    localparam int PAGE_W     = lru_pkg::PAGE_BITS_DEF;
    localparam int STAMP_W    = lru_pkg::TIME_BITS_DEF;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic                          hit;
        logic [lru_pkg::FIDX_W-1:0]    frame;
        logic                          evicted;
        logic [PAGE_W-1:0]             victim;
        logic [lru_pkg::COUNT_W-1:0]   faults;
    } lookup_t;

    logic [PAGE_W-1:0]          held_page [NUM_FRAMES];
    logic                       resident  [NUM_FRAMES];
    logic [STAMP_W-1:0]         stamp     [NUM_FRAMES];
    logic [STAMP_W-1:0]         ref_clock;
    logic [lru_pkg::COUNT_W-1:0] fault_tally;
    logic [lru_pkg::CFG_W-1:0]  frames_cfg;
    lookup_t                    lookup_q [$];

    initial
    begin
        pending    = 0;
        mismatches = 0;
    end

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    // LRU lookup of one page reference; updates the frame table and queues the outcome.
    task automatic resolve_reference(input logic [PAGE_W-1:0] p);
        lookup_t                 r;
        int                      span;
        int                      slot;
        logic                    found;
        logic                    have_empty;
        logic                    have_oldest;
        logic [STAMP_W-1:0]      oldest;
        r           = '0;
        slot        = 0;
        found       = 1'b0;
        have_empty  = 1'b0;
        have_oldest = 1'b0;
        oldest      = '1;
        span = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
        for (int k = 0; k < span; k++)
            if (!found && resident[k] && held_page[k] == p)
            begin
                found = 1'b1;
                slot  = k;
            end
        if (found)
        begin
            r.hit       = 1'b1;
            stamp[slot] = ref_clock;
        end
        else
        begin
            for (int k = 0; k < span; k++)
            begin
                if (!have_empty)
                begin
                    if (!resident[k])
                    begin
                        have_empty = 1'b1;
                        slot       = k;
                    end
                    else if (!have_oldest || stamp[k] < oldest)
                    begin
                        have_oldest = 1'b1;
                        oldest      = stamp[k];
                        slot        = k;
                    end
                end
            end
            if (!have_empty)
            begin
                r.evicted = 1'b1;
                r.victim  = held_page[slot];
            end
            held_page[slot] = p;
            resident[slot]  = 1'b1;
            stamp[slot]     = ref_clock;
            if (fault_tally != '1)
                fault_tally = fault_tally + 1'b1;
        end
        if (ref_clock != '1)
            ref_clock = ref_clock + 1'b1;
        r.frame  = slot[lru_pkg::FIDX_W-1:0];
        r.faults = fault_tally;
        lookup_q.push_back(r);
    endtask

    task automatic check_result();
        lookup_t e;
        if (lookup_q.size() == 0)
        begin
            report("result word with no lookup outstanding");
            return;
        end
        e = lookup_q.pop_front();
        if (hit !== e.hit)
            report($sformatf("hit: expected %0b got %0b", e.hit, hit));
        if (frame_index !== e.frame)
            report($sformatf("frame_index: expected %0d got %0d", e.frame, frame_index));
        if (evicted_valid !== e.evicted)
            report($sformatf("evicted_valid: expected %0b got %0b", e.evicted, evicted_valid));
        if (evicted_page !== e.victim)
            report($sformatf("evicted_page: expected %h got %h", e.victim, evicted_page));
        if (fault_total !== e.faults)
            report($sformatf("fault_total: expected %0d got %0d", e.faults, fault_total));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_FRAMES; k++)
            begin
                held_page[k] = '0;
                resident[k]  = 1'b0;
                stamp[k]     = '0;
            end
            ref_clock   = '0;
            fault_tally = '0;
            frames_cfg  = lru_pkg::CFG_RESET;
            lookup_q.delete();
            pending     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_we)
                frames_cfg = cfg_wdata;
            if (in_valid && !in_stall)
                resolve_reference(page);
            pending = lookup_q.size();
        end
    end

endmodule

[bench/tb_lru_page_replacement.sv]
`timescale 1ns / 1ps

module tb_lru_page_replacement;

    localparam int CYCLE_LIMIT = 400000;
    // Settle time once the last result word is in: covers the scan of the widest config.
    localparam int SETTLE      = 16;
    localparam int PHASES      = 12;

    // Receiver stall behaviors; each runs for a random stretch of cycles.
    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_LIGHT  = 2'd1;
    localparam logic [1:0] STALL_HEAVY  = 2'd2;
    localparam logic [1:0] STALL_PERIOD = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [lru_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [15:0]                   page = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          hit;
    logic [lru_pkg::FIDX_W-1:0]    frame_index;
    logic                          evicted_valid;
    logic [15:0]                   evicted_page;
    logic [lru_pkg::COUNT_W-1:0]   fault_total;

    int                            pending;
    int                            mismatches;
    int                            cycle_count = 0;
    int                            burst_left = 0;
    logic [1:0]                    stall_mode = STALL_NONE;
    int                            stall_left = 0;
    logic [15:0]                   page_pool [$];

    // Frame counts per random phase: both extremes, the clamped values 0 and 15,
    // and enough others that every register bit is toggled.
    logic [lru_pkg::CFG_W-1:0]     phase_frames [PHASES] =
        '{4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd0, 4'd15, 4'd4, 4'd6, 4'd1, 4'd12, 4'd9};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lru_page_replacement u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    lru_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result-side backpressure. Switch behavior after each random stretch so stalls
    // land on every phase of the scan, with quiet stretches in between.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 300);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIOD: out_stall <= (stall_left % 8 < 5);
            default:      out_stall <= 1'b0;
        endcase
    end

    // Drop valid and hold for a number of cycles.
    task automatic idle_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Present one page word and hold it until the block takes it. Open a new
    // burst first when the current one is used up, usually after a random gap.
    task automatic send_page(input logic [15:0] p);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        burst_left = burst_left - 1;
        in_valid <= 1'b1;
        page     <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and hold until every expected result word is in, then let the scan settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write frames_in_use; only ever done with the block drained.
    task automatic write_frames(input logic [lru_pkg::CFG_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Fill the pool with a working set a little larger than the active frames,
    // so most references hit or evict within a small set of pages.
    task automatic build_pool(input logic [lru_pkg::CFG_W-1:0] frames);
        int span;
        span = (frames == 0) ? 1 : ((frames > 8) ? 8 : frames);
        page_pool.delete();
        repeat (span + $urandom_range(1, 4))
            page_pool.push_back(16'($urandom_range(0, 65535)));
    endtask

    initial
    begin
        int items;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config of 8 frames. Fill all frames with extreme and
        // alternating patterns, hit on one, then force two LRU evictions.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h0004);
        send_page(16'h0005);
        send_page(16'hFFFF);
        send_page(16'h0005);

        // Zero frames acts as one: frame 0 alone, replace, replace again, then hit.
        write_frames(4'd0);
        send_page(16'h0000);
        send_page(16'h1234);
        send_page(16'h1234);

        // Widen to 15 (acts as 8): outer frames kept their pages while hidden.
        write_frames(4'd15);
        send_page(16'h0001);
        send_page(16'h0000);
        send_page(16'h5555);

        // Narrow to one frame: a ref outside the window must miss.
        write_frames(4'd1);
        send_page(16'h0002);
        send_page(16'h7777);

        // Random phases: mostly the phase's working set, some wide-range noise.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_frames(phase_frames[ph]);
            build_pool(phase_frames[ph]);
            items = $urandom_range(80, 120);
            for (int i = 0; i < items; i++)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_page(page_pool[$urandom_range(0, page_pool.size() - 1)]);
                else
                    send_page(16'($urandom_range(0, 65535)));
                // Drain fully now and then, mid-phase.
                if (i == items / 2 && ph % 3 == 0)
                    wait_idle();
                // Slowly drift the working set.
                if ($urandom_range(0, 31) == 0)
                    page_pool[$urandom_range(0, page_pool.size() - 1)] =
                        16'($urandom_range(0, 65535));
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
